>>> rtl/mppr_pkg.sv
// shared types and constants for the med pixel reconstruction block
`timescale 1ns / 1ps

package mppr_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int CODE_W  = 9;
  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int IDX_W   = 1;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int OUT_DEPTH = 3;

  typedef enum logic [2:0] {
    PH_ROW0  = 3'b001,
    PH_COL0  = 3'b010,
    PH_INNER = 3'b100
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               done;
  } result_t;

endpackage

>>> rtl/mppr_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module mppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/med_predictive_pixel_reconstruct.sv
// top level: med predictive pixel reconstruction of one 8-bit channel
// each accepted item is registered in the second stage, then written to the output queue
// throughput: one item per cycle while the output queue has room, set by the read-modify-write of the
//   row memory in the second stage, with forwarding from the write to the next read
// reset: counters, phase, pipeline and output queue clear at once; the row and column
//   memories are not cleared and need no clearing pass, so items are taken right after reset
`timescale 1ns / 1ps

module med_predictive_pixel_reconstruct #(
  parameter int MAX_WIDTH  = mppr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mppr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mppr_pkg::IDX_W-1:0]         cfg_index,
  input  logic [mppr_pkg::DIM_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [mppr_pkg::CODE_W-1:0] code_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mppr_pkg::PIX_W-1:0]         pixel_value,
  output logic [mppr_pkg::COORD_W-1:0]       pixel_row,
  output logic [mppr_pkg::COORD_W-1:0]       pixel_col,
  output logic                               channel_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = mppr_pkg::PIX_W;
  localparam int QD = mppr_pkg::OUT_DEPTH;
  localparam int QP = $clog2(QD);
  localparam int QC = $clog2(QD + 1);

  // configuration
  logic [mppr_pkg::DIM_W-1:0] image_width;
  logic [mppr_pkg::DIM_W-1:0] image_height;
  logic [WW-1:0]              width_eff;
  logic [HW-1:0]              height_eff;

  // sequencing state
  mppr_pkg::phase_t phase, phase_next;
  logic [RW-1:0]    row_count, row_next;
  logic [CW-1:0]    col_count, col_next;
  logic             col_last, row_last;
  logic             done_s0, first_s0;
  logic [RW-1:0]    row_s0;
  logic [CW-1:0]    col_s0;
  logic             accept;

  // second stage
  logic             s1_valid;
  mppr_pkg::phase_t s1_phase;
  logic [PW-1:0]    s1_code;
  logic [RW-1:0]    s1_row;
  logic [CW-1:0]    s1_col;
  logic             s1_done;
  logic             s1_first;

  logic [PW-1:0] above_rdata, fc_rdata;
  logic          fwd_b, fwd_fc;
  logic [PW-1:0] fwd_b_data, fwd_fc_data;
  logic [PW-1:0] left_pixel, upper_left_pixel, fc_prev;
  logic [PW-1:0] b_val, fc_val, a_val, ul_val, hi, lo, pred, pix;
  logic          above_we, fc_we;

  // output queue
  mppr_pkg::result_t queue [QD];
  logic [QP-1:0]     wr_ptr, rd_ptr;
  logic [QC-1:0]     q_count;
  logic              push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mppr_pkg::IMAGE_WIDTH_RST;
      image_height <= mppr_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mppr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        mppr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      height_eff = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(image_height);
    end
  end

  assign col_last = (WW'(col_count) + WW'(1)) >= width_eff;
  assign row_last = (HW'(row_count) + HW'(1)) >= height_eff;
  assign accept   = in_valid & in_ready;

  always_comb begin
    phase_next = phase;
    row_next   = row_count;
    col_next   = col_count;
    done_s0    = 1'b0;
    first_s0   = 1'b0;
    row_s0     = row_count;
    col_s0     = col_count;
    unique case (phase)
      mppr_pkg::PH_ROW0: begin
        row_s0 = '0;
        if (col_last) begin
          if (height_eff == HW'(1)) begin
            done_s0 = 1'b1;
          end else begin
            phase_next = mppr_pkg::PH_COL0;
            row_next   = RW'(1);
            col_next   = '0;
          end
        end else begin
          col_next = col_count + CW'(1);
        end
      end
      mppr_pkg::PH_COL0: begin
        col_s0 = '0;
        if (row_last) begin
          if (width_eff == WW'(1)) begin
            done_s0 = 1'b1;
          end else begin
            phase_next = mppr_pkg::PH_INNER;
            row_next   = RW'(1);
            col_next   = CW'(1);
          end
        end else begin
          row_next = row_count + RW'(1);
        end
      end
      mppr_pkg::PH_INNER: begin
        first_s0 = col_count <= CW'(1);
        if (col_last) begin
          if (row_last) begin
            done_s0 = 1'b1;
          end else begin
            row_next = row_count + RW'(1);
            col_next = CW'(1);
          end
        end else begin
          col_next = col_count + CW'(1);
        end
      end
      default: begin
        phase_next = mppr_pkg::PH_ROW0;
        row_next   = '0;
        col_next   = '0;
      end
    endcase
    if (done_s0) begin
      phase_next = mppr_pkg::PH_ROW0;
      row_next   = '0;
      col_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mppr_pkg::PH_ROW0;
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        phase     <= phase_next;
        row_count <= row_next;
        col_count <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_phase <= phase;
      s1_code  <= code_value[PW-1:0];
      s1_row   <= row_s0;
      s1_col   <= col_s0;
      s1_done  <= done_s0;
      s1_first <= first_s0;
    end
  end

  mppr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_above_row (
    .clk   (clk),
    .we    (above_we),
    .waddr (s1_col),
    .wdata (pix),
    .raddr (col_count),
    .rdata (above_rdata)
  );

  mppr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_HEIGHT)
  ) u_first_column (
    .clk   (clk),
    .we    (fc_we),
    .waddr (s1_row),
    .wdata (s1_code),
    .raddr (row_count),
    .rdata (fc_rdata)
  );

  // med prediction and reconstruction
  always_comb begin
    b_val  = fwd_b ? fwd_b_data : above_rdata;
    fc_val = fwd_fc ? fwd_fc_data : fc_rdata;
    a_val  = s1_first ? fc_val : left_pixel;
    ul_val = s1_first ? fc_prev : upper_left_pixel;
    hi     = (a_val > b_val) ? a_val : b_val;
    lo     = (a_val > b_val) ? b_val : a_val;
    if (ul_val >= hi) begin
      pred = lo;
    end else if (ul_val <= lo) begin
      pred = hi;
    end else begin
      pred = a_val + b_val - ul_val;
    end
    if (s1_phase == mppr_pkg::PH_INNER) begin
      pix = s1_code + pred;
    end else begin
      pix = s1_code;
    end
  end

  assign above_we = s1_valid &
                    ((s1_phase == mppr_pkg::PH_ROW0) || (s1_phase == mppr_pkg::PH_INNER));
  assign fc_we    = s1_valid & ((s1_phase == mppr_pkg::PH_COL0) ||
                    ((s1_phase == mppr_pkg::PH_ROW0) && (s1_col == '0)));

  // write-to-read forwarding for same entry
  always_ff @(posedge clk) begin
    fwd_b       <= above_we && (s1_col == col_count);
    fwd_b_data  <= pix;
    fwd_fc      <= fc_we && (s1_row == row_count);
    fwd_fc_data <= s1_code;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && (s1_phase == mppr_pkg::PH_INNER)) begin
      left_pixel       <= pix;
      upper_left_pixel <= b_val;
      if (s1_first) begin
        fc_prev <= fc_val;
      end
    end
    if (s1_valid && (s1_phase == mppr_pkg::PH_ROW0) && (s1_col == '0)) begin
      fc_prev <= s1_code;
    end
  end

  // output queue
  assign push      = s1_valid;
  assign out_valid = q_count != '0;
  assign pop       = out_valid & out_ready;
  assign in_ready  = ((QC + 1)'(q_count) + (QC + 1)'(s1_valid)) < (QC + 1)'(QD);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP'(QD - 1)) ? '0 : wr_ptr + QP'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP'(QD - 1)) ? '0 : rd_ptr + QP'(1);
      end
      q_count <= q_count + QC'(push) - QC'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{pixel: pix,
                         row:   mppr_pkg::COORD_W'(s1_row),
                         col:   mppr_pkg::COORD_W'(s1_col),
                         done:  s1_done};
    end
  end

  assign pixel_value  = queue[rd_ptr].pixel;
  assign pixel_row    = queue[rd_ptr].row;
  assign pixel_col    = queue[rd_ptr].col;
  assign channel_done = queue[rd_ptr].done;

endmodule

>>> rtl/mppr_checker.sv
// port-level checker for the med pixel reconstruction block, with its bind
`timescale 1ns / 1ps

module mppr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mppr_pkg::PIX_W-1:0]   pixel_value,
  input logic [mppr_pkg::COORD_W-1:0] pixel_row,
  input logic [mppr_pkg::COORD_W-1:0] pixel_col,
  input logic                         channel_done
);

  // empty and ready right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_ready && !out_valid)
    else $error("block not empty after reset");

  // input back-pressure only while results are pending
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // an empty output stays empty while no item is taken or held in the second stage
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result without an item");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(pixel_row)
      && $stable(pixel_col) && $stable(channel_done))
    else $error("stalled result changed");

endmodule

bind med_predictive_pixel_reconstruct mppr_checker u_mppr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pixel_value  (pixel_value),
  .pixel_row    (pixel_row),
  .pixel_col    (pixel_col),
  .channel_done (channel_done)
);

>>> sim/tb.sv
// testbench for med_predictive_pixel_reconstruct: self-checking with a MED pixel predictor
`timescale 1ns / 1ps

module tb;
  import mppr_pkg::*;

  localparam int RANDOM_ITEMS  = 550;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 1_000_000;

  class pixel_scoreboard;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [PIX_W-1:0] above_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] first_col [MAX_HEIGHT_DEF];
    logic [PIX_W-1:0] left_pix;
    logic [PIX_W-1:0] upleft_pix;
    phase_t           phase;
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    result_t          pending [$];
    int unsigned      mismatches;

    function new();
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      foreach (above_row[i]) above_row[i] = '0;
      foreach (first_col[i]) first_col[i] = '0;
      left_pix   = '0;
      upleft_pix = '0;
      phase      = PH_ROW0;
      row_cnt    = 0;
      col_cnt    = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data;
      else height_reg = data;
    endfunction

    // predicts the pixel for one accepted code, returns the channel-done flag
    function bit note_code(logic [CODE_W-1:0] code);
      int unsigned w, h, r, c, a, b, ul, hi, lo, pred;
      logic [PIX_W-1:0] pix;
      bit last;
      result_t res;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
      r = row_cnt;
      c = col_cnt;
      last = 1'b0;
      case (phase)
        PH_COL0: begin
          pix = code[PIX_W-1:0];
          first_col[r] = pix;
          if (r + 1 >= h) begin
            if (w <= 1) begin
              last = 1'b1;
            end else begin
              phase   = PH_INNER;
              row_cnt = 1;
              col_cnt = 1;
            end
          end else begin
            row_cnt = r + 1;
          end
          c = 0;
        end
        PH_INNER: begin
          if (c <= 1) begin
            a  = 32'(first_col[r]);
            ul = 32'(first_col[r-1]);
          end else begin
            a  = 32'(left_pix);
            ul = 32'(upleft_pix);
          end
          b  = 32'(above_row[c]);
          hi = (a > b) ? a : b;
          lo = (a > b) ? b : a;
          if (ul >= hi) pred = lo;
          else if (ul <= lo) pred = hi;
          else pred = a + b - ul;
          pix = code[PIX_W-1:0] + pred[PIX_W-1:0];
          above_row[c] = pix;
          left_pix     = pix;
          upleft_pix   = b[PIX_W-1:0];
          if (c + 1 >= w) begin
            if (r + 1 >= h) begin
              last = 1'b1;
            end else begin
              row_cnt = r + 1;
              col_cnt = 1;
            end
          end else begin
            col_cnt = c + 1;
          end
        end
        default: begin
          pix = code[PIX_W-1:0];
          above_row[c] = pix;
          if (c == 0) first_col[0] = pix;
          r = 0;
          if (c + 1 >= w) begin
            if (h <= 1) begin
              last = 1'b1;
            end else begin
              phase   = PH_COL0;
              row_cnt = 1;
              col_cnt = 0;
            end
          end else begin
            col_cnt = c + 1;
          end
        end
      endcase
      if (last) begin
        phase      = PH_ROW0;
        row_cnt    = 0;
        col_cnt    = 0;
        left_pix   = '0;
        upleft_pix = '0;
      end
      res.pixel = pix;
      res.row   = r[COORD_W-1:0];
      res.col   = c[COORD_W-1:0];
      res.done  = last;
      pending.insert(pending.size(), res);
      return last;
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("pixel with no item pending: value %0d row %0d col %0d",
               got.pixel, got.row, got.col);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.pixel !== want.pixel) begin
        $error("pixel_value: expected %0d, got %0d", want.pixel, got.pixel);
        mismatches++;
      end
      if (got.row !== want.row) begin
        $error("pixel_row: expected %0d, got %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("pixel_col: expected %0d, got %0d", want.col, got.col);
        mismatches++;
      end
      if (got.done !== want.done) begin
        $error("channel_done: expected %0d, got %0d", want.done, got.done);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_write    = 1'b0;
  logic [IDX_W-1:0]          cfg_index    = '0;
  logic [DIM_W-1:0]          cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic signed [CODE_W-1:0]  code_value   = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [PIX_W-1:0]          pixel_value;
  logic [COORD_W-1:0]        pixel_row;
  logic [COORD_W-1:0]        pixel_col;
  logic                      channel_done;

  pixel_scoreboard sb;
  int unsigned     items_sent = 0;
  int unsigned     burst_left = 0;
  int unsigned     stall_left = 0;
  int unsigned     stall_mode = 0;
  int unsigned     cycles     = 0;

  med_predictive_pixel_reconstruct i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_value   (code_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .channel_done (channel_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern: ready, light stalls, heavy stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_pixel({pixel_value, pixel_row, pixel_col, channel_done});
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, value[DIM_W-1:0]);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_code(int value, output bit last);
    @(negedge clk);
    in_valid   <= 1'b1;
    code_value <= value[CODE_W-1:0];
    do @(posedge clk); while (!in_ready);
    last = sb.note_code(value[CODE_W-1:0]);
    items_sent++;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // feeds one channel; optional mid-channel shrink of a dimension while idle
  task automatic run_channel(bit allow_resize);
    bit last;
    int value;
    do begin
      value = $urandom_range(0, 510);
      send_code(value - 255, last);
      if (!last && allow_resize && $urandom_range(0, 79) == 0) begin
        wait_drained();
        if ($urandom_range(0, 1))
          write_reg(REG_IMAGE_WIDTH,
                    $urandom_range(0, sb.clamp_dim(sb.width_reg, MAX_WIDTH_DEF)));
        else
          write_reg(REG_IMAGE_HEIGHT,
                    $urandom_range(0, sb.clamp_dim(sb.height_reg, MAX_HEIGHT_DEF)));
      end
    end while (!last);
  endtask

  initial begin
    int corner_codes [9];
    bit last;
    int unsigned w, h;
    int value;
    corner_codes = '{255, -255, 0, -1, 128, 255, -255, 1, -1};
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // 3x3 channel: raw byte extremes, residual wrap both ways
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    foreach (corner_codes[i]) send_code(corner_codes[i], last);
    wait_drained();
    // zero width acts as one: column only
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 2);
    send_code(7, last);
    send_code(-7, last);
    wait_drained();
    // zero height acts as one: row only
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_code(100, last);
    send_code(-100, last);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 1);
    send_code(-128, last);

    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      w = $urandom_range(0, 12);
      h = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) w = $urandom_range(13, 48);
        else h = $urandom_range(13, 48);
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, h);
      run_channel(1'b1);
    end

    // width above the maximum, row cut short by a shrink while idle
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 1);
    repeat (24) begin
      value = $urandom_range(0, 510);
      send_code(value - 255, last);
    end
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 0);
    run_channel(1'b0);

    // height above the maximum, column cut short by a shrink while idle
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 2047);
    repeat (24) begin
      value = $urandom_range(0, 510);
      send_code(value - 255, last);
    end
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, 0);
    run_channel(1'b0);

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
